[hdl/acir_pkg.sv]
// Shared types and constants for the AC IR frame encoder.
package acir_pkg;

   localparam int FRAME_LEN     = 14;
   localparam int SECT_LEN      = 7;
   localparam int FRAME_BITS    = FRAME_LEN * 8;
   localparam int SECT_BITS     = SECT_LEN * 8;
   localparam int SECT_ENTRIES  = 116;
   localparam int FRAME_ENTRIES = 234;
   localparam int TEMP_MIN      = 16;
   localparam int TEMP_MAX      = 30;
   localparam int DUR_W         = 16;
   localparam int IDX_W         = 8;
   localparam int CSR_IDX_W     = 3;

   localparam logic [DUR_W-1:0] SECT1_GAP_US = 16'd2886;
   localparam logic [DUR_W-1:0] SECT2_GAP_US = 16'd20000;
   localparam logic [IDX_W-1:0] LAST_ENTRY   = IDX_W'(FRAME_ENTRIES - 1);

   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   localparam frame_type FRAME_TMPL = {
      8'hF0, 8'h15, 8'h00, 8'h71, 8'hAE, 8'h02, 8'h01,
      8'hF0, 8'h00, 8'h00, 8'h00, 8'h0F, 8'h92, 8'h02
   };

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_NEXT = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HDR_MARK     = 3'd0,
      CSR_HDR_SPACE    = 3'd1,
      CSR_SECT_MARK    = 3'd2,
      CSR_SECT_SPACE   = 3'd3,
      CSR_BIT_MARK     = 3'd4,
      CSR_ONE_SPACE    = 3'd5,
      CSR_ZERO_SPACE   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DUR_W-1:0] hdr_mark_us;
      logic [DUR_W-1:0] hdr_space_us;
      logic [DUR_W-1:0] section_mark_us;
      logic [DUR_W-1:0] section_space_us;
      logic [DUR_W-1:0] bit_mark_us;
      logic [DUR_W-1:0] one_space_us;
      logic [DUR_W-1:0] zero_space_us;
   } timing_cfg_type;

   localparam timing_cfg_type CFG_RESET = '{
      hdr_mark_us:      16'd690,
      hdr_space_us:     16'd17844,
      section_mark_us:  16'd3086,
      section_space_us: 16'd8864,
      bit_mark_us:      16'd586,
      one_space_us:     16'd1432,
      zero_space_us:    16'd436
   };

   typedef struct packed {
      logic             op;
      logic             power_on;
      logic [7:0]       temp_c;
      logic [2:0]       mode;
      logic [2:0]       fan;
      logic             swing;
   } req_item_type;

   typedef struct packed {
      logic [DUR_W-1:0] duration_us;
      logic             is_mark;
      logic             last;
   } entry_type;

endpackage

[hdl/acir_if.sv]
// Request and response channel interfaces for the AC IR frame encoder.
interface acir_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic       power_on;
   logic [7:0] temp_c;
   logic [2:0] mode;
   logic [2:0] fan;
   logic       swing;

   modport source (output valid, op, power_on, temp_c, mode, fan, swing, input ready);
   modport sink   (input valid, op, power_on, temp_c, mode, fan, swing, output ready);
endinterface

interface acir_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] duration_us;
   logic        is_mark;
   logic        last;

   modport source (output valid, duration_us, is_mark, last, input ready);
   modport sink   (input valid, duration_us, is_mark, last, output ready);
endinterface

[hdl/ac_ir_frame_encoder_unit.sv]
// AC IR frame encoder top level: request register, frame store, response register.
//
//  channel   dir   beat fields
//  req_bus   in    op, power_on, temp_c, mode, fan, swing
//  rsp_bus   out   duration_us, is_mark, last
//  csr_*     in    csr_we, csr_index, csr_wdata (write only)
//
// A beat enters the request register, is decoded from there and its entry lands in
// the response register; one beat a cycle while the response is not stalled.
// Load beats and next beats while idle give no response beat.
// A full frame is 234 response beats; the last carries last = 1.
// Reset clears control state and timing registers; the frame store is not reset.
// A stalled response holds the request register, which then drops req ready.
module ac_ir_frame_encoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   acir_req_if.sink                          req_bus,
   acir_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [acir_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [acir_pkg::DUR_W-1:0]        csr_wdata
);

   logic                          s1_valid_ff, s1_valid_in;
   acir_pkg::req_item_type        s1_item_ff, s1_item_in;
   acir_pkg::frame_type           frame_ff, frame_in;
   logic                          sending_ff, sending_in;
   logic [acir_pkg::IDX_W-1:0]    index_ff, index_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   acir_pkg::entry_type           rsp_data_ff, rsp_data_in;
   acir_pkg::timing_cfg_type      cfg_ff, cfg_in;

   acir_pkg::frame_type           built_frame;
   acir_pkg::entry_type           entry;
   logic                          s2_free;
   logic                          s1_adv;
   logic                          req_fire;
   logic                          is_load;
   logic                          is_next;

   acir_frame_build u_build (
      .power_on (s1_item_ff.power_on),
      .temp_c   (s1_item_ff.temp_c),
      .mode     (s1_item_ff.mode),
      .fan      (s1_item_ff.fan),
      .swing    (s1_item_ff.swing),
      .frame    (built_frame)
   );

   acir_entry_sel u_sel (
      .entry_idx (index_ff),
      .frame     (frame_ff),
      .cfg       (cfg_ff),
      .entry     (entry)
   );

   assign s2_free       = !rsp_valid_ff || rsp_bus.ready;
   assign s1_adv        = s1_valid_ff && s2_free;
   assign req_bus.ready = !s1_valid_ff || s2_free;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign is_load       = s1_adv && (s1_item_ff.op == acir_pkg::OP_LOAD);
   assign is_next       = s1_adv && (s1_item_ff.op == acir_pkg::OP_NEXT) && sending_ff;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.duration_us = rsp_data_ff.duration_us;
   assign rsp_bus.is_mark     = rsp_data_ff.is_mark;
   assign rsp_bus.last        = rsp_data_ff.last;

   always_comb begin
      s1_valid_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_item_in  = s1_item_ff;
      if (req_fire) begin
         s1_item_in.op       = req_bus.op;
         s1_item_in.power_on = req_bus.power_on;
         s1_item_in.temp_c   = req_bus.temp_c;
         s1_item_in.mode     = req_bus.mode;
         s1_item_in.fan      = req_bus.fan;
         s1_item_in.swing    = req_bus.swing;
      end

      frame_in   = is_load ? built_frame : frame_ff;
      sending_in = sending_ff;
      index_in   = index_ff;
      if (is_load) begin
         sending_in = 1'b1;
         index_in   = '0;
      end else if (is_next) begin
         if (entry.last) begin
            sending_in = 1'b0;
            index_in   = '0;
         end else begin
            index_in   = index_ff + 8'd1;
         end
      end

      rsp_valid_in = s2_free ? is_next : rsp_valid_ff;
      rsp_data_in  = is_next ? entry : rsp_data_ff;

      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            acir_pkg::CSR_HDR_MARK:   cfg_in.hdr_mark_us      = csr_wdata;
            acir_pkg::CSR_HDR_SPACE:  cfg_in.hdr_space_us     = csr_wdata;
            acir_pkg::CSR_SECT_MARK:  cfg_in.section_mark_us  = csr_wdata;
            acir_pkg::CSR_SECT_SPACE: cfg_in.section_space_us = csr_wdata;
            acir_pkg::CSR_BIT_MARK:   cfg_in.bit_mark_us      = csr_wdata;
            acir_pkg::CSR_ONE_SPACE:  cfg_in.one_space_us     = csr_wdata;
            acir_pkg::CSR_ZERO_SPACE: cfg_in.zero_space_us    = csr_wdata;
            default:                  cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         sending_ff   <= 1'b0;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= acir_pkg::CFG_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         sending_ff   <= sending_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      s1_item_ff  <= s1_item_in;
      frame_ff    <= frame_in;
      rsp_data_ff <= rsp_data_in;
   end

   // index stays inside the frame
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= acir_pkg::LAST_ENTRY)
      else $error("entry index beyond frame");

   // idle implies index parked at zero
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> index_ff == '0)
      else $error("index not zero while idle");

   // final entry ends the transmission
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (is_next && entry.last) |=> !sending_ff && index_ff == '0)
      else $error("still sending after last entry");

   // request side only stalls behind a blocked response
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_bus.ready))
      else $error("request stalled without cause");

endmodule

[hdl/acir_frame_build.sv]
// Builds the 14-byte frame from the settings and seals both sections.
module acir_frame_build (
   input  logic                power_on,
   input  logic [7:0]          temp_c,
   input  logic [2:0]          mode,
   input  logic [2:0]          fan,
   input  logic                swing,
   output acir_pkg::frame_type frame
);

   function automatic logic [7:0] sect_sum (input logic [acir_pkg::SECT_BITS-1:0] s);
      logic [5:0] cnt;
      cnt = 6'($countones(s[7:0])) + 6'($countones(s[11:8]))
          + 6'($countones(s[23:20])) + 6'($countones(s[55:24]));
      return {2'b00, cnt} ^ 8'hFF;
   endfunction

   logic [7:0]          temp_clamp;
   logic [3:0]          temp_code;
   logic [2:0]          mode_code;
   logic [2:0]          fan_code;
   logic [1:0]          pwr_code;
   logic [2:0]          swing_code;
   acir_pkg::frame_type raw;
   logic [7:0]          sum_a;
   logic [7:0]          sum_b;

   always_comb begin
      if (temp_c < 8'(acir_pkg::TEMP_MIN)) begin
         temp_clamp = 8'(acir_pkg::TEMP_MIN);
      end else if (temp_c > 8'(acir_pkg::TEMP_MAX)) begin
         temp_clamp = 8'(acir_pkg::TEMP_MAX);
      end else begin
         temp_clamp = temp_c;
      end
      temp_code  = 4'(temp_clamp - 8'(acir_pkg::TEMP_MIN));
      mode_code  = (mode > 3'd4) ? 3'd0 : mode;
      case (fan)
         3'd1:    fan_code = 3'd2;
         3'd2:    fan_code = 3'd4;
         3'd3:    fan_code = 3'd5;
         default: fan_code = 3'd0;
      endcase
      pwr_code   = power_on ? 2'd3 : 2'd0;
      swing_code = swing ? 3'd1 : 3'd7;

      raw     = acir_pkg::FRAME_TMPL;
      raw[6]  = {raw[6][7:6], pwr_code, raw[6][3:0]};
      raw[13] = {raw[13][7:6], pwr_code, raw[13][3:0]};
      raw[11] = {temp_code, raw[11][3:0]};
      raw[12] = {raw[12][7], mode_code, raw[12][3:0]};
      raw[12] = {raw[12][7:4], fan_code, raw[12][0]};
      raw[9]  = {raw[9][7], swing_code, raw[9][3:0]};

      sum_a = sect_sum(raw[6:0]);
      sum_b = sect_sum(raw[13:7]);

      frame     = raw;
      frame[1]  = {sum_a[3:0], raw[1][3:0]};
      frame[2]  = {raw[2][7:4], sum_a[7:4]};
      frame[8]  = {sum_b[3:0], raw[8][3:0]};
      frame[9]  = {raw[9][7:4], sum_b[7:4]};
   end

endmodule

[hdl/acir_entry_sel.sv]
// Maps an entry index to its timing entry from the stored frame.
module acir_entry_sel (
   input  logic [acir_pkg::IDX_W-1:0] entry_idx,
   input  acir_pkg::frame_type        frame,
   input  acir_pkg::timing_cfg_type   cfg,
   output acir_pkg::entry_type        entry
);

   logic [acir_pkg::FRAME_BITS-1:0] frame_flat;
   logic [7:0]                      r;
   logic                            sec;
   logic [6:0]                      p;
   logic [6:0]                      q;
   logic [6:0]                      bit_idx;
   logic                            bit_val;

   always_comb begin
      frame_flat = frame;
      r       = entry_idx - 8'd2;
      sec     = (r >= 8'(acir_pkg::SECT_ENTRIES));
      p       = sec ? 7'(r - 8'(acir_pkg::SECT_ENTRIES)) : 7'(r);
      q       = p - 7'd2;
      bit_idx = 7'(q[6:1]) + (sec ? 7'(acir_pkg::SECT_BITS) : 7'd0);
      bit_val = frame_flat[bit_idx];

      entry.is_mark = 1'b0;
      entry.last    = (entry_idx == acir_pkg::LAST_ENTRY);
      if (entry_idx == 8'd0) begin
         entry.duration_us = cfg.hdr_mark_us;
         entry.is_mark     = 1'b1;
      end else if (entry_idx == 8'd1) begin
         entry.duration_us = cfg.hdr_space_us;
      end else if (p == 7'd0) begin
         entry.duration_us = cfg.section_mark_us;
         entry.is_mark     = 1'b1;
      end else if (p == 7'd1) begin
         entry.duration_us = cfg.section_space_us;
      end else if (p < 7'(acir_pkg::SECT_ENTRIES - 2)) begin
         if (!q[0]) begin
            entry.duration_us = cfg.bit_mark_us;
            entry.is_mark     = 1'b1;
         end else begin
            entry.duration_us = bit_val ? cfg.one_space_us : cfg.zero_space_us;
         end
      end else if (p == 7'(acir_pkg::SECT_ENTRIES - 2)) begin
         entry.duration_us = cfg.bit_mark_us;
         entry.is_mark     = 1'b1;
      end else begin
         entry.duration_us = sec ? acir_pkg::SECT2_GAP_US : acir_pkg::SECT1_GAP_US;
      end
   end

endmodule
